### hw/rtl/pcsb_pkg.sv
package pcsb_pkg;

    localparam int unsigned RANGE_W     = 18;
    localparam int unsigned COORD_W     = 18;
    localparam int unsigned ANGLE_W     = 16;
    localparam int unsigned CFG_W       = 18;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned SEL_W       = 10;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned CX_W        = 30;
    localparam int unsigned ATAN_DEPTH  = 24;
    localparam int unsigned NUM_W       = 18;
    localparam int unsigned DEN_W       = 17;

    localparam logic [RANGE_W-1:0] EMPTY_RANGE  = 18'h3FFFF;
    localparam logic [21:0]        MAX_RANGE    = 22'd262142;
    localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;

    typedef enum logic [2:0] {
        REG_HEIGHT_LOW  = 3'd0,
        REG_HEIGHT_HIGH = 3'd1,
        REG_NEAR_LIMIT  = 3'd2,
        REG_FAR_LIMIT   = 3'd3,
        REG_ANGLE_START = 3'd4,
        REG_ANGLE_STOP  = 3'd5,
        REG_ANGLE_STEP  = 3'd6,
        REG_BIN_COUNT   = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        RSN_NONE       = 3'd0,
        RSN_INVALID    = 3'd1,
        RSN_HEIGHT     = 3'd2,
        RSN_RANGE      = 3'd3,
        RSN_ANGLE      = 3'd4,
        RSN_NOT_NEARER = 3'd5
    } t_reason;

    typedef enum logic {
        FUNC_INSERT  = 1'b0,
        FUNC_READOUT = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CORD,
        ST_CHECK,
        ST_DIV,
        ST_RD,
        ST_UPD,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_ITER,
        COR_MUL,
        COR_RND
    } t_cor_state;

    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/point_cloud_to_scan_binner.sv
// channel  | handshake          | payload
// input    | i_valid / o_stall  | i_func i_pos_x i_pos_y i_pos_z i_world_x i_world_y
//          |                    | i_point_valid i_bin_select
// output   | o_valid / i_stall  | o_accepted o_reject_reason o_bin_index o_bin_range
//          |                    | o_world_x_out o_world_y_out o_bin_filled
// config   | i_cfg_we           | i_cfg_idx i_cfg_data
// one item at a time; an insert runs an iterative cordic, a multiply, a bit-serial
// divider, then a bin read and a write back; a readout reads its bin and writes it
// back empty; a missing point goes straight to the result
// after reset a clearing pass writes every bin of the memory empty, o_stall high
// a finished item waits in the output register; the next item is taken meanwhile
module point_cloud_to_scan_binner #(
    parameter int unsigned MAX_BINS      = 1024,
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_func,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_pos_z,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_world_x,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_world_y,
    input  logic                                 i_point_valid,
    input  logic [pcsb_pkg::SEL_W-1:0]           i_bin_select,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_accepted,
    output logic [2:0]                           o_reject_reason,
    output logic [pcsb_pkg::SEL_W-1:0]           o_bin_index,
    output logic [pcsb_pkg::RANGE_W-1:0]         o_bin_range,
    output logic signed [pcsb_pkg::COORD_W-1:0]  o_world_x_out,
    output logic signed [pcsb_pkg::COORD_W-1:0]  o_world_y_out,
    output logic                                 o_bin_filled,
    input  logic                                 i_cfg_we,
    input  logic [pcsb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pcsb_pkg::CFG_W-1:0]           i_cfg_data
);
    import pcsb_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_BINS);
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned MW  = 1 + RANGE_W + 2 * COORD_W;

    t_state r_state, n_state;

    logic signed [17:0] r_hl, r_hh;
    logic [17:0]        r_nl, r_fl;
    logic signed [15:0] r_as, r_ae;
    logic [15:0]        r_step;
    logic [10:0]        r_cnt;

    logic               r_func;
    logic signed [17:0] r_pz, r_wx, r_wy;
    logic [RANGE_W-1:0] r_range;
    logic signed [15:0] r_ang;
    logic [NUM_W-1:0]   r_idx;

    logic               r_res_acc, r_res_fill;
    logic [2:0]         r_res_rsn;
    logic [SEL_W-1:0]   r_res_idx;
    logic [RANGE_W-1:0] r_res_rng;
    logic [17:0]        r_res_wx, r_res_wy;

    logic               r_ovalid, r_o_acc, r_o_fill;
    logic [2:0]         r_o_rsn;
    logic [SEL_W-1:0]   r_o_idx;
    logic [RANGE_W-1:0] r_o_rng;
    logic [17:0]        r_o_wx, r_o_wy;

    logic [AW-1:0]      r_clr;

    logic               in_acc, out_free;
    logic               cor_start, cor_done, div_start, div_done;
    logic [RANGE_W-1:0] cor_range;
    logic [ANGLE_W-1:0] cor_angle;
    logic [NUM_W-1:0]   div_quo, quo_clamp;
    logic [15:0]        step_eff, diff;
    logic [CW-1:0]      cnt_eff;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic [2:0]         chk_rsn;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [MW-1:0]      ram_wdata, ram_rdata;
    logic               st_fill;
    logic [RANGE_W-1:0] st_range;
    logic [17:0]        st_wx, st_wy;
    logic               nearer;

    assign {st_fill, st_range, st_wy, st_wx} = ram_rdata;

    always_comb begin
        in_acc   = i_valid && !o_stall;
        out_free = !r_ovalid || !i_stall;
        step_eff = (r_step == 16'd0) ? 16'd1 : r_step;
        if (r_cnt == 11'd0) begin
            cnt_eff = CW'(1);
        end else if (32'(r_cnt) > MAX_BINS) begin
            cnt_eff = CW'(MAX_BINS);
        end else begin
            cnt_eff = CW'(r_cnt);
        end
        diff = 16'(r_ang - r_as);
        num  = {1'b0, diff, 1'b0} + NUM_W'(step_eff);
        den  = {step_eff, 1'b0};
        quo_clamp = (div_quo > NUM_W'(cnt_eff - CW'(1))) ? NUM_W'(cnt_eff - CW'(1))
                                                         : div_quo;
        if (r_pz < r_hl || r_pz > r_hh) begin
            chk_rsn = RSN_HEIGHT;
        end else if (r_range < r_nl || r_range > r_fl) begin
            chk_rsn = RSN_RANGE;
        end else if (r_ang < r_as || r_ang > r_ae) begin
            chk_rsn = RSN_ANGLE;
        end else begin
            chk_rsn = RSN_NONE;
        end
        nearer = (r_range < st_range);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(MAX_BINS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_READOUT) begin
                        n_state = (32'(i_bin_select) < MAX_BINS) ? ST_RD : ST_FIN;
                    end else begin
                        n_state = i_point_valid ? ST_CORD : ST_FIN;
                    end
                end
            end
            ST_CORD:  if (cor_done) n_state = ST_CHECK;
            ST_CHECK: n_state = (chk_rsn == RSN_NONE) ? ST_DIV : ST_FIN;
            ST_DIV:   if (div_done) n_state = ST_RD;
            ST_RD:    n_state = ST_UPD;
            ST_UPD:   n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = (r_state != ST_IDLE);
        cor_start = (r_state == ST_IDLE) && in_acc && (i_func == FUNC_INSERT)
                    && i_point_valid;
        div_start = (r_state == ST_CHECK) && (chk_rsn == RSN_NONE);
        ram_raddr = (r_state == ST_IDLE) ? AW'(i_bin_select) : AW'(r_idx);
        ram_we    = 1'b0;
        ram_waddr = AW'(r_idx);
        ram_wdata = {1'b0, EMPTY_RANGE, r_wy, r_wx};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            ST_UPD: begin
                if (r_func == FUNC_READOUT) begin
                    ram_we = 1'b1;
                end else begin
                    ram_we    = nearer;
                    ram_wdata = {1'b1, r_range, r_wy, r_wx};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_hl     <= -18'sd1000;
            r_hh     <= 18'sd1000;
            r_nl     <= 18'd100;
            r_fl     <= 18'd30000;
            r_as     <= 16'sh8000;
            r_ae     <= 16'sd32767;
            r_step   <= 16'd182;
            r_cnt    <= 11'd360;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_HEIGHT_LOW:  r_hl   <= i_cfg_data;
                    REG_HEIGHT_HIGH: r_hh   <= i_cfg_data;
                    REG_NEAR_LIMIT:  r_nl   <= i_cfg_data;
                    REG_FAR_LIMIT:   r_fl   <= i_cfg_data;
                    REG_ANGLE_START: r_as   <= i_cfg_data[15:0];
                    REG_ANGLE_STOP:  r_ae   <= i_cfg_data[15:0];
                    REG_ANGLE_STEP:  r_step <= i_cfg_data[15:0];
                    REG_BIN_COUNT:   r_cnt  <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_func <= i_func;
                r_pz   <= i_pos_z;
                r_wx   <= i_world_x;
                r_wy   <= i_world_y;
                r_idx  <= NUM_W'(i_bin_select);
                r_res_acc  <= 1'b0;
                r_res_fill <= 1'b0;
                r_res_wx   <= '0;
                r_res_wy   <= '0;
                if (i_func == FUNC_READOUT) begin
                    r_res_rsn <= RSN_NONE;
                    r_res_idx <= i_bin_select;
                    r_res_rng <= EMPTY_RANGE;
                end else begin
                    r_res_rsn <= RSN_INVALID;
                    r_res_idx <= '0;
                    r_res_rng <= '0;
                end
            end
            ST_CORD: begin
                r_range   <= cor_range;
                r_ang     <= cor_angle;
                r_res_rng <= cor_range;
            end
            ST_CHECK: begin
                r_res_rsn <= chk_rsn;
            end
            ST_DIV: begin
                r_idx     <= quo_clamp;
                r_res_idx <= SEL_W'(quo_clamp);
            end
            ST_UPD: begin
                if (r_func == FUNC_READOUT) begin
                    r_res_rng  <= st_range;
                    r_res_fill <= st_fill;
                    r_res_wx   <= st_fill ? st_wx : '0;
                    r_res_wy   <= st_fill ? st_wy : '0;
                end else if (nearer) begin
                    r_res_acc <= 1'b1;
                    r_res_rsn <= RSN_NONE;
                end else begin
                    r_res_rsn <= RSN_NOT_NEARER;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    r_o_acc  <= r_res_acc;
                    r_o_rsn  <= r_res_rsn;
                    r_o_idx  <= r_res_idx;
                    r_o_rng  <= r_res_rng;
                    r_o_wx   <= r_res_wx;
                    r_o_wy   <= r_res_wy;
                    r_o_fill <= r_res_fill;
                end
            end
            default: begin
            end
        endcase
    end

    pcsb_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (i_pos_x),
        .i_y     (i_pos_y),
        .o_done  (cor_done),
        .o_range (cor_range),
        .o_angle (cor_angle)
    );

    pcsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    pcsb_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid         = r_ovalid;
    assign o_accepted      = r_o_acc;
    assign o_reject_reason = r_o_rsn;
    assign o_bin_index     = r_o_idx;
    assign o_bin_range     = r_o_rng;
    assign o_world_x_out   = r_o_wx;
    assign o_world_y_out   = r_o_wy;
    assign o_bin_filled    = r_o_fill;

endmodule

### hw/rtl/pcsb_ram.sv
module pcsb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pcsb_cordic.sv
module pcsb_cordic #(
    parameter int unsigned STAGES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_x,
    input  logic signed [pcsb_pkg::COORD_W-1:0]  i_y,
    output logic                                 o_done,
    output logic [pcsb_pkg::RANGE_W-1:0]         o_range,
    output logic [pcsb_pkg::ANGLE_W-1:0]         o_angle
);
    import pcsb_pkg::*;

    localparam int unsigned NSTG = (STAGES < ATAN_DEPTH) ? STAGES : ATAN_DEPTH;

    t_cor_state r_state, n_state;
    logic signed [CX_W-1:0] r_x, r_y, n_x, n_y;
    logic [31:0]            r_z, n_z;
    logic [4:0]             r_i;
    logic                   r_zero;
    logic [59:0]            r_prod;
    logic signed [CX_W-1:0] xs, ys, dx, dy;
    logic [59:0]            rsum;
    logic [31:0]            zsum;

    always_comb begin
        n_state = r_state;
        case (r_state)
            COR_IDLE: if (i_start) n_state = COR_ITER;
            COR_ITER: if (r_i == 5'(NSTG - 1)) n_state = COR_MUL;
            COR_MUL:  n_state = COR_RND;
            COR_RND:  n_state = COR_IDLE;
            default:  n_state = COR_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == COR_RND);
    end

    always_comb begin
        xs = {{(CX_W-COORD_W-8){i_x[COORD_W-1]}}, i_x, 8'b0};
        ys = {{(CX_W-COORD_W-8){i_y[COORD_W-1]}}, i_y, 8'b0};
        n_x = xs;
        n_y = ys;
        n_z = 32'h0;
        if (xs < 0) begin
            if (ys >= 0) begin
                n_x = ys;
                n_y = -xs;
                n_z = 32'h40000000;
            end else begin
                n_x = -ys;
                n_y = xs;
                n_z = 32'hC0000000;
            end
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        rsum = r_prod + (60'd1 << 37);
        zsum = r_z + 32'h8000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= COR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            COR_IDLE: begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_i    <= 5'd0;
                r_zero <= (i_x == 0) && (i_y == 0);
            end
            COR_ITER: begin
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_turns(r_i);
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_turns(r_i);
                end
                r_i <= r_i + 5'd1;
            end
            COR_MUL: begin
                r_prod <= 60'($unsigned(r_x)) * 60'(INV_GAIN_Q30);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_zero) begin
            o_range = '0;
            o_angle = '0;
        end else begin
            o_range = (rsum[59:38] > MAX_RANGE) ? MAX_RANGE[RANGE_W-1:0]
                                                : rsum[38 +: RANGE_W];
            o_angle = zsum[31:16];
        end
    end

endmodule

### hw/rtl/pcsb_div.sv
module pcsb_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pcsb_pkg::NUM_W-1:0]   i_num,
    input  logic [pcsb_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [pcsb_pkg::NUM_W-1:0]   o_quo
);
    import pcsb_pkg::*;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_busy && (r_cnt == 5'(NUM_W - 1));
    assign o_quo  = {r_num[NUM_W-2:0], fits};

endmodule
